>>> rtl/core/tmsl_pkg.sv
package tmsl_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_SIZE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATLAS_COLUMNS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATLAS_SPACING = 3'd4;

   localparam logic [6:0] MAP_DIM_RESET   = 7'd64;
   localparam logic [7:0] TILE_SIZE_RESET = 8'd16;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam int COORD_W    = 16;
   localparam int ID_FIELD_W = 13;
   localparam int SRC_X_W    = 17;
   localparam int SRC_Y_W    = 21;
   localparam int WORLD_W    = 14;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;

   localparam int DIV_BITS  = 12;
   localparam int DIV_CNT_W = 4;

   typedef struct packed {
      logic clear;
      logic capture;
      logic write;
      logic read;
      logic load;
      logic div_step;
      logic mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_get;
   } status_type;

endpackage

>>> rtl/core/tmsl_ram.sv
module tmsl_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tmsl_ctrl.sv
module tmsl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tmsl_pkg::status_type status,
   output tmsl_pkg::cmd_type    cmd
);

   import tmsl_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACCESS,
      S_LOAD,
      S_DIV,
      S_MUL,
      S_OUT
   } state_type;

   state_type             state_ff;
   logic                  req_tready_ff;
   logic                  rsp_tvalid_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic                  out_free;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      cmd.clear    = (state_ff == S_CLEAR);
      cmd.capture  = (state_ff == S_IDLE) && req_tvalid && req_tready_ff;
      cmd.write    = (state_ff == S_ACCESS) && !status.is_get;
      cmd.read     = (state_ff == S_ACCESS) && status.is_get;
      cmd.load     = (state_ff == S_LOAD);
      cmd.div_step = (state_ff == S_DIV);
      cmd.mul      = (state_ff == S_MUL);
      cmd.out_load = (state_ff == S_OUT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         req_tready_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !cmd.out_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (status.clear_last) begin
                  state_ff      <= S_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_tvalid && req_tready_ff) begin
                  state_ff      <= S_ACCESS;
                  req_tready_ff <= 1'b0;
               end
            end
            S_ACCESS: begin
               if (status.is_get) begin
                  state_ff <= S_LOAD;
               end else begin
                  state_ff      <= S_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            S_LOAD: begin
               state_ff   <= S_DIV;
               div_cnt_ff <= '0;
            end
            S_DIV: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff      <= S_IDLE;
                  req_tready_ff <= 1'b1;
                  rsp_tvalid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= S_IDLE;
               req_tready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

>>> rtl/core/tmsl_dpath.sv
module tmsl_dpath #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int ID_BITS     = 13
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tmsl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmsl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [tmsl_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   output logic [tmsl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  tmsl_pkg::cmd_type                    cmd,
   output tmsl_pkg::status_type                 status
);

   import tmsl_pkg::*;

   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ID_W   = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
   localparam int CELL_W = ID_W + 1;
   localparam int MAX_ID = (1 << (ID_W - 1)) - 1;

   logic [6:0]                  map_width_ff;
   logic [6:0]                  map_height_ff;
   logic [7:0]                  tile_size_ff;
   logic [7:0]                  atlas_cols_ff;
   logic [7:0]                  atlas_spacing_ff;
   logic [ADDR_W-1:0]           clr_addr_ff;

   logic                        op_ff;
   logic [COORD_W-1:0]          x_ff;
   logic [COORD_W-1:0]          y_ff;
   logic signed [ID_FIELD_W-1:0] nid_ff;
   logic                        npass_ff;

   logic signed [ID_W-1:0]      cell_id_ff;
   logic signed [ID_W-1:0]      cell_id_in;
   logic                        cell_pass_ff;
   logic [WORLD_W-1:0]          world_x_ff;
   logic [WORLD_W-1:0]          world_y_ff;
   logic [7:0]                  rem_ff;
   logic [DIV_BITS-1:0]         quo_ff;
   logic [SRC_X_W-1:0]          src_x_ff;
   logic [SRC_Y_W-1:0]          src_y_ff;
   logic [RSP_DATA_W-1:0]       rsp_data_ff;

   logic [COORD_W:0]            width_lim;
   logic [COORD_W:0]            height_lim;
   logic                        in_bounds;
   logic [31:0]                 lin_addr;
   logic [ADDR_W-1:0]           cell_addr;
   logic signed [ID_FIELD_W-1:0] nid_sat;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [CELL_W-1:0]           wr_data;
   logic [CELL_W-1:0]           rd_data;
   logic signed [ID_FIELD_W-1:0] rd_id_wide;
   logic signed [ID_FIELD_W-1:0] id_wide;
   logic                        id_empty;
   logic                        src_ok;
   logic [9:0]                  div_diff;
   logic [8:0]                  atlas_step;
   logic [21:0]                 world_x_prod;
   logic [21:0]                 world_y_prod;
   logic [SRC_X_W-1:0]          src_x_prod;
   logic [SRC_Y_W-1:0]          src_y_prod;

   assign width_lim  = (17'(map_width_ff) > 17'(MAX_COLUMNS)) ?
                       17'(MAX_COLUMNS) : 17'(map_width_ff);
   assign height_lim = (17'(map_height_ff) > 17'(MAX_ROWS)) ?
                       17'(MAX_ROWS) : 17'(map_height_ff);
   assign in_bounds  = !x_ff[COORD_W-1] && !y_ff[COORD_W-1] &&
                       ({1'b0, x_ff} < width_lim) && ({1'b0, y_ff} < height_lim);
   assign lin_addr   = {16'b0, y_ff} * 32'(MAX_COLUMNS) + {16'b0, x_ff};
   assign cell_addr  = lin_addr[ADDR_W-1:0];

   always_comb begin
      nid_sat = nid_ff;
      if (nid_ff < -13'sd1) begin
         nid_sat = -13'sd1;
      end else if (nid_ff > $signed(13'(MAX_ID))) begin
         nid_sat = $signed(13'(MAX_ID));
      end
   end

   assign wr_en   = cmd.clear || (cmd.write && in_bounds);
   assign wr_addr = cmd.clear ? clr_addr_ff : cell_addr;
   assign wr_data = cmd.clear ? {1'b1, ID_W'(0)} : {npass_ff, nid_sat[ID_W-1:0]};

   tmsl_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read),
      .rd_addr (cell_addr),
      .rd_data (rd_data)
   );

   assign cell_id_in = $signed(rd_data[ID_W-1:0]);
   assign rd_id_wide = ID_FIELD_W'(cell_id_in);
   assign id_wide    = ID_FIELD_W'(cell_id_ff);
   assign id_empty   = (id_wide == -13'sd1);
   assign src_ok     = !id_wide[ID_FIELD_W-1] && (atlas_cols_ff != 8'd0);

   assign div_diff     = {1'b0, rem_ff, quo_ff[DIV_BITS-1]} - {2'b0, atlas_cols_ff};
   assign atlas_step   = 9'(tile_size_ff) + 9'(atlas_spacing_ff);
   assign world_x_prod = {8'b0, x_ff[WORLD_W-1:0]} * {14'b0, tile_size_ff};
   assign world_y_prod = {8'b0, y_ff[WORLD_W-1:0]} * {14'b0, tile_size_ff};
   assign src_x_prod   = {9'b0, rem_ff} * {8'b0, atlas_step};
   assign src_y_prod   = {9'b0, quo_ff} * {12'b0, atlas_step};

   assign status.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign status.is_get     = (op_ff == OP_GET);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff     <= MAP_DIM_RESET;
         map_height_ff    <= MAP_DIM_RESET;
         tile_size_ff     <= TILE_SIZE_RESET;
         atlas_cols_ff    <= 8'd0;
         atlas_spacing_ff <= 8'd0;
         clr_addr_ff      <= '0;
      end else begin
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAP_WIDTH:     map_width_ff     <= csr_wdata[6:0];
               CSR_MAP_HEIGHT:    map_height_ff    <= csr_wdata[6:0];
               CSR_TILE_SIZE:     tile_size_ff     <= csr_wdata;
               CSR_ATLAS_COLUMNS: atlas_cols_ff    <= csr_wdata;
               CSR_ATLAS_SPACING: atlas_spacing_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser;
         x_ff     <= req_tdata[15:0];
         y_ff     <= req_tdata[31:16];
         nid_ff   <= $signed(req_tdata[44:32]);
         npass_ff <= req_tdata[45];
      end
      if (cmd.load) begin
         cell_id_ff   <= cell_id_in;
         cell_pass_ff <= rd_data[CELL_W-1];
         world_x_ff   <= world_x_prod[WORLD_W-1:0];
         world_y_ff   <= world_y_prod[WORLD_W-1:0];
         rem_ff       <= 8'd0;
         quo_ff       <= rd_id_wide[DIV_BITS-1:0];
      end
      if (cmd.div_step) begin
         if (!div_diff[9]) begin
            rem_ff <= div_diff[7:0];
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[6:0], quo_ff[DIV_BITS-1]};
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         src_x_ff <= src_ok ? src_x_prod : '0;
         src_y_ff <= src_ok ? src_y_prod : '0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {6'b0,
                         in_bounds ? world_y_ff : WORLD_W'(0),
                         in_bounds ? world_x_ff : WORLD_W'(0),
                         in_bounds ? src_y_ff : SRC_Y_W'(0),
                         in_bounds ? src_x_ff : SRC_X_W'(0),
                         in_bounds && id_empty,
                         in_bounds && cell_pass_ff,
                         in_bounds ? id_wide : ID_FIELD_W'(0),
                         in_bounds};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

>>> rtl/core/tile_map_store_lookup_unit.sv
// Get: the word is accepted, the cell is read, the 12-step restoring divider finds the
// atlas row and column, the source offsets are multiplied, and the result is loaded once
// the output register is free; the next word is taken only then. Set: the cell is written
// if in bounds, no result, and the next word is taken after the write. Reset: synchronous,
// active high; registers return to their defaults and a clearing pass writes every cell
// (MAX_COLUMNS * MAX_ROWS cells, 4096 by default) with req_tready low; configuration writes are taken during the pass.
module tile_map_store_lookup_unit #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int ID_BITS     = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tmsl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmsl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cell_x[15:0], cell_y[31:16], new_tile_id[44:32], new_passable[45], zero[47:46]
   input  logic [tmsl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // in_bounds[0], tile_id[13:1], is_passable[14], is_empty[15], source_x[32:16],
   // source_y[53:33], world_x[67:54], world_y[81:68], zero[87:82]
   output logic [tmsl_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import tmsl_pkg::*;

   cmd_type    cmd;
   status_type status;

   tmsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmsl_dpath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .ID_BITS     (ID_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tmsl_pkg::*;

   localparam int MAP_COLS       = 64;
   localparam int MAP_ROWS       = 64;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 20000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [1:0]         pad;
      logic               new_passable;
      logic signed [12:0] new_tile_id;
      logic signed [15:0] cell_y;
      logic signed [15:0] cell_x;
   } cell_access_type;

   typedef struct packed {
      logic [5:0]         pad;
      logic [13:0]        world_y;
      logic [13:0]        world_x;
      logic [20:0]        source_y;
      logic [16:0]        source_x;
      logic               is_empty;
      logic               is_passable;
      logic signed [12:0] tile_id;
      logic               in_bounds;
   } tile_rsp_type;

   typedef struct packed {
      logic signed [12:0] id;
      logic               passable;
   } map_cell_type;

   typedef enum logic [1:0] {ROW_SET, ROW_GET, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      cell_access_type        acc;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      bit                     fixed;
      tile_rsp_type           rsp;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // cell_x[15:0], cell_y[31:16], new_tile_id[44:32], new_passable[45], zero[47:46]
   logic [REQ_DATA_W-1:0]  req_tdata;
   // opcode[0]
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // in_bounds[0], tile_id[13:1], is_passable[14], is_empty[15], source_x[32:16],
   // source_y[53:33], world_x[67:54], world_y[81:68], zero[87:82]
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   map_cell_type cell_mem [0:MAP_COLS*MAP_ROWS-1];
   logic [6:0]  cfg_width;
   logic [6:0]  cfg_height;
   logic [7:0]  cfg_tile;
   logic [7:0]  cfg_cols;
   logic [7:0]  cfg_spacing;

   tile_rsp_type   pending_lookups [$];
   script_row_type script [$];
   int          fault_count = 0;
   bit          req_idle_en = 1;
   bit          rsp_idle_en = 1;
   bit          squeeze_req = 0;

   tile_map_store_lookup_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit lookup_cell(input logic op, input cell_access_type acc,
                                      output tile_rsp_type rsp);
      int xi, yi, w, h, idx, id, step, cols;
      bit inb;
      xi = $signed(acc.cell_x);
      yi = $signed(acc.cell_y);
      w = (cfg_width > MAP_COLS) ? MAP_COLS : cfg_width;
      h = (cfg_height > MAP_ROWS) ? MAP_ROWS : cfg_height;
      inb = xi >= 0 && yi >= 0 && xi < w && yi < h;
      idx = yi * MAP_COLS + xi;
      rsp = '0;
      if (op == OP_SET) begin
         if (inb) begin
            id = $signed(acc.new_tile_id);
            if (id < -1) id = -1;
            cell_mem[idx].id = 13'(id);
            cell_mem[idx].passable = acc.new_passable;
         end
         return 1'b0;
      end
      if (!inb) return 1'b1;
      id = $signed(cell_mem[idx].id);
      step = int'(cfg_tile) + int'(cfg_spacing);
      cols = cfg_cols;
      rsp.in_bounds = 1'b1;
      rsp.tile_id = cell_mem[idx].id;
      rsp.is_passable = cell_mem[idx].passable;
      rsp.is_empty = (id == -1);
      if (id >= 0 && cols != 0) begin
         rsp.source_x = 17'((id % cols) * step);
         rsp.source_y = 21'((id / cols) * step);
      end
      rsp.world_x = 14'(xi * int'(cfg_tile));
      rsp.world_y = 14'(yi * int'(cfg_tile));
      return 1'b1;
   endfunction

   function automatic tile_rsp_type mk_rsp(int inb, int id, int pass, int empty,
                                           int sx, int sy, int wx, int wy);
      tile_rsp_type r;
      r = '0;
      r.in_bounds = inb[0];
      r.tile_id = 13'(id);
      r.is_passable = pass[0];
      r.is_empty = empty[0];
      r.source_x = 17'(sx);
      r.source_y = 21'(sy);
      r.world_x = 14'(wx);
      r.world_y = 14'(wy);
      return r;
   endfunction

   function automatic cell_access_type mk_access(int x, int y, int id, int pass);
      cell_access_type a;
      a = '0;
      a.cell_x = 16'(x);
      a.cell_y = 16'(y);
      a.new_tile_id = 13'(id);
      a.new_passable = pass[0];
      return a;
   endfunction

   function automatic script_row_type set_row(int x, int y, int id, int pass);
      script_row_type r;
      r = '{kind: ROW_SET, acc: mk_access(x, y, id, pass), csr_idx: '0, csr_val: '0,
            fixed: 1'b0, rsp: '0};
      return r;
   endfunction

   function automatic script_row_type get_row(int x, int y);
      script_row_type r;
      r = '{kind: ROW_GET, acc: mk_access(x, y, 0, 0), csr_idx: '0, csr_val: '0,
            fixed: 1'b0, rsp: '0};
      return r;
   endfunction

   function automatic script_row_type fixed_row(int x, int y, tile_rsp_type rsp);
      script_row_type r;
      r = get_row(x, y);
      r.fixed = 1'b1;
      r.rsp = rsp;
      return r;
   endfunction

   function automatic script_row_type csr_row(logic [CSR_INDEX_W-1:0] idx, int val);
      script_row_type r;
      r = '{kind: ROW_CSR, acc: '0, csr_idx: idx, csr_val: 8'(val), fixed: 1'b0,
            rsp: '0};
      return r;
   endfunction

   function automatic void add_row(script_row_type r);
      script.insert(script.size(), r);
   endfunction

   function automatic logic [15:0] pick_coord(int lim);
      int r;
      r = $urandom_range(0, 99);
      if (lim > 0 && r < 45) return 16'($urandom_range(0, ((lim < 8) ? lim : 8) - 1));
      if (lim > 0 && r < 75) return 16'($urandom_range(0, lim - 1));
      if (r < 90) return 16'(int'($urandom_range(0, lim + 4)) - 2);
      return 16'($urandom);
   endfunction

   function automatic logic [12:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 13'h1fff;
      if (r < 25) return 13'($urandom);
      if (r < 45) return 13'($urandom_range(0, 300));
      return 13'($urandom_range(0, 4095));
   endfunction

   task automatic send_word(input logic op, input cell_access_type acc, input bit fixed,
                            input tile_rsp_type fixed_rsp);
      tile_rsp_type want;
      bit gives;
      if (req_idle_en && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= acc;
      do @(posedge clock); while (!req_tready);
      gives = lookup_cell(op, acc, want);
      if (gives) pending_lookups.insert(pending_lookups.size(), fixed ? fixed_rsp : want);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      case (idx)
         CSR_MAP_WIDTH:     cfg_width = val[6:0];
         CSR_MAP_HEIGHT:    cfg_height = val[6:0];
         CSR_TILE_SIZE:     cfg_tile = val;
         CSR_ATLAS_COLUMNS: cfg_cols = val;
         CSR_ATLAS_SPACING: cfg_spacing = val;
         default: ;
      endcase
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int w, input int h, input int ts, input int cols,
                            input int sp, input int count, input bit quiet,
                            input bit squeeze);
      cell_access_type acc;
      logic op;
      int w_eff, h_eff;
      settle();
      write_csr(CSR_MAP_WIDTH, 8'(w));
      write_csr(CSR_MAP_HEIGHT, 8'(h));
      write_csr(CSR_TILE_SIZE, 8'(ts));
      write_csr(CSR_ATLAS_COLUMNS, 8'(cols));
      write_csr(CSR_ATLAS_SPACING, 8'(sp));
      w_eff = (cfg_width > MAP_COLS) ? MAP_COLS : cfg_width;
      h_eff = (cfg_height > MAP_ROWS) ? MAP_ROWS : cfg_height;
      req_idle_en = !quiet;
      rsp_idle_en = !quiet;
      for (int k = 0; k < count; k++) begin
         if (squeeze && k == count / 4) squeeze_req = 1'b1;
         op = $urandom_range(0, 1) ? OP_GET : OP_SET;
         acc = '0;
         acc.cell_x = pick_coord(w_eff);
         acc.cell_y = pick_coord(h_eff);
         acc.new_tile_id = pick_id();
         acc.new_passable = $urandom_range(0, 1);
         send_word(op, acc, 1'b0, '0);
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin : stimulus
      tile_rsp_type oob;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_SET;
      for (int i = 0; i < MAP_COLS * MAP_ROWS; i++) begin
         cell_mem[i].id = '0;
         cell_mem[i].passable = 1'b1;
      end
      cfg_width = MAP_DIM_RESET;
      cfg_height = MAP_DIM_RESET;
      cfg_tile = TILE_SIZE_RESET;
      cfg_cols = '0;
      cfg_spacing = '0;

      oob = mk_rsp(0, 0, 0, 0, 0, 0, 0, 0);
      add_row(fixed_row(0, 0, mk_rsp(1, 0, 1, 0, 0, 0, 0, 0)));
      add_row(fixed_row(63, 63, mk_rsp(1, 0, 1, 0, 0, 0, 1008, 1008)));
      add_row(fixed_row(64, 0, oob));
      add_row(fixed_row(-1, 0, oob));
      add_row(fixed_row(0, -32768, oob));
      add_row(fixed_row(32767, 32767, oob));
      add_row(set_row(-32768, 5, 7, 0));
      add_row(set_row(3, 4, -1, 0));
      add_row(fixed_row(3, 4, mk_rsp(1, -1, 0, 1, 0, 0, 48, 64)));
      add_row(set_row(5, 6, 4095, 1));
      add_row(fixed_row(5, 6, mk_rsp(1, 4095, 1, 0, 0, 0, 80, 96)));
      add_row(set_row(7, 8, -4096, 1));
      add_row(fixed_row(7, 8, mk_rsp(1, -1, 1, 1, 0, 0, 112, 128)));
      add_row(set_row(63, 0, 100, 0));
      add_row(set_row(0, 63, -2, 0));
      add_row(get_row(0, 63));
      add_row(csr_row(CSR_ATLAS_COLUMNS, 10));
      add_row(csr_row(CSR_ATLAS_SPACING, 3));
      add_row(get_row(5, 6));
      add_row(get_row(3, 4));
      add_row(csr_row(CSR_TILE_SIZE, 0));
      add_row(get_row(5, 6));
      add_row(csr_row(CSR_MAP_WIDTH, 0));
      add_row(fixed_row(0, 0, oob));
      add_row(csr_row(CSR_MAP_WIDTH, 127));
      add_row(csr_row(CSR_MAP_HEIGHT, 2));
      add_row(get_row(63, 1));
      add_row(fixed_row(0, 2, oob));
      add_row(set_row(63, 1, 9, 1));
      add_row(csr_row(CSR_MAP_HEIGHT, 64));
      add_row(get_row(63, 0));
      add_row(csr_row(CSR_UNUSED, 255));
      add_row(csr_row(CSR_TILE_SIZE, 255));
      add_row(csr_row(CSR_ATLAS_COLUMNS, 255));
      add_row(csr_row(CSR_ATLAS_SPACING, 255));
      add_row(get_row(5, 6));
      add_row(get_row(63, 63));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_CSR: begin
               settle();
               write_csr(script[i].csr_idx, script[i].csr_val);
            end
            ROW_SET: send_word(OP_SET, script[i].acc, 1'b0, '0);
            default: send_word(OP_GET, script[i].acc, script[i].fixed, script[i].rsp);
         endcase
      end

      run_phase(64, 64, 16, 16, 0, 220, 1'b0, 1'b1);
      run_phase(1, 1, 1, 1, 0, 200, 1'b0, 1'b0);
      run_phase(40, 24, 8, 7, 2, 220, 1'b1, 1'b0);
      run_phase(127, 127, 255, 255, 255, 220, 1'b0, 1'b0);
      run_phase(0, 64, 0, 0, 0, 60, 1'b0, 1'b0);
      repeat (3) begin
         run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), 200, 1'b0, 1'b0);
      end

      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : rsp_pacing
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= !(rsp_idle_en && $urandom_range(0, 99) < 35);
      end
   end

   always @(posedge clock) begin : rsp_check
      tile_rsp_type got;
      tile_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_lookups.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("unexpected result word %h", got);
         end else begin
            want = pending_lookups.pop_front();
            if (got.in_bounds !== want.in_bounds || got.tile_id !== want.tile_id ||
                got.is_passable !== want.is_passable || got.is_empty !== want.is_empty ||
                got.source_x !== want.source_x || got.source_y !== want.source_y ||
                got.world_x !== want.world_x || got.world_y !== want.world_y) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("expected: inb=%0b id=%0d pass=%0b empty=%0b src=%0d,%0d world=%0d,%0d",
                           want.in_bounds, want.tile_id, want.is_passable, want.is_empty,
                           want.source_x, want.source_y, want.world_x, want.world_y);
                  $display("actual:   inb=%0b id=%0d pass=%0b empty=%0b src=%0d,%0d world=%0d,%0d",
                           got.in_bounds, got.tile_id, got.is_passable, got.is_empty,
                           got.source_x, got.source_y, got.world_x, got.world_y);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
            stuck = 0;
         end else begin
            stuck++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
